@@ rtl/mmp_pkg.sv @@
// Shared types and constants for the mecanum mixer / PWM pipeline.
// No dependencies; used by every other file of the block.
package mmp_pkg;

   localparam int NUM_WHEELS = 4;
   localparam int IN_W       = 8;    // speed, turn, strafe
   localparam int DUTY_W     = 10;   // mixed duty, -384..383
   localparam int MAG_W      = 9;    // duty magnitude / bound
   localparam int LIM_W      = 7;    // scale_limit
   localparam int NUM_W      = 17;   // (duty + bound) * limit
   localparam int QUO_W      = 8;    // rescale quotient, at most 2 * limit
   localparam int PCT_W      = 7;    // final duty magnitude, at most 127
   localparam int DIR_W      = 2;
   localparam int PCT_FULL   = 100;

   localparam logic [LIM_W-1:0] LIM_RESET = 7'd90;

   localparam int WHEEL_FR = 0;
   localparam int WHEEL_FL = 1;
   localparam int WHEEL_RR = 2;
   localparam int WHEEL_RL = 3;

   localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

   typedef logic signed [DUTY_W-1:0] duty_type;
   typedef logic [MAG_W-1:0]         mag_type;
   typedef logic [LIM_W-1:0]         lim_type;
   typedef logic [NUM_W-1:0]         num_type;
   typedef logic [QUO_W-1:0]         quo_type;

   // mixer -> divider
   typedef struct packed {
      num_type  [NUM_WHEELS-1:0] num;
      mag_type                   bound;
      duty_type [NUM_WHEELS-1:0] duty;
      lim_type                   lim;
      logic                      rescale;
   } div_in_type;

   // one divider stage
   typedef struct packed {
      num_type  [NUM_WHEELS-1:0] rem;
      quo_type  [NUM_WHEELS-1:0] quo;
      mag_type                   bound;
      duty_type [NUM_WHEELS-1:0] duty;
      lim_type                   lim;
      logic                      rescale;
   } div_st_type;

   // divider -> PWM conversion
   typedef struct packed {
      quo_type  [NUM_WHEELS-1:0] quo;
      duty_type [NUM_WHEELS-1:0] duty;
      lim_type                   lim;
      logic                      rescale;
   } pwm_in_type;

endpackage

@@ rtl/mmp_if.sv @@
// Valid/ready channel interfaces for drive commands and wheel results.
// Depends on mmp_pkg.
interface mmp_req_if import mmp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] speed;
   logic signed [IN_W-1:0] turn;
   logic signed [IN_W-1:0] strafe;

   modport source (output valid, speed, turn, strafe, input ready);
   modport sink   (input valid, speed, turn, strafe, output ready);
endinterface

interface mmp_rsp_if import mmp_pkg::*; #(parameter int PWM_BITS = 10) ();
   logic                valid;
   logic                ready;
   logic [DIR_W-1:0]    dir_front_right;
   logic [PWM_BITS-1:0] pwm_front_right;
   logic [DIR_W-1:0]    dir_front_left;
   logic [PWM_BITS-1:0] pwm_front_left;
   logic [DIR_W-1:0]    dir_rear_right;
   logic [PWM_BITS-1:0] pwm_rear_right;
   logic [DIR_W-1:0]    dir_rear_left;
   logic [PWM_BITS-1:0] pwm_rear_left;

   modport source (output valid, dir_front_right, pwm_front_right, dir_front_left,
                   pwm_front_left, dir_rear_right, pwm_rear_right, dir_rear_left,
                   pwm_rear_left, input ready);
   modport sink   (input valid, dir_front_right, pwm_front_right, dir_front_left,
                   pwm_front_left, dir_rear_right, pwm_rear_right, dir_rear_left,
                   pwm_rear_left, output ready);
endinterface

@@ rtl/mmp_mix.sv @@
// Front of the pipeline: wheel mixing, bound search, rescale numerators.
// Four register stages; depends on mmp_pkg.
module mmp_mix import mmp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [IN_W-1:0] in_speed,
   input  logic signed [IN_W-1:0] in_turn,
   input  logic signed [IN_W-1:0] in_strafe,
   input  lim_type                in_lim,
   output logic                   out_valid,
   input  logic                   out_ready,
   output div_in_type             out_data
);

   logic [3:0] vld_ff;
   logic [3:0] vld_in;
   logic [3:0] rdy;

   assign rdy[3]   = !vld_ff[3] || out_ready;
   assign rdy[2]   = !vld_ff[2] || rdy[3];
   assign rdy[1]   = !vld_ff[1] || rdy[2];
   assign rdy[0]   = !vld_ff[0] || rdy[1];
   assign in_ready = rdy[0];
   assign vld_in   = {vld_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < 4; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // stage 1: mix
   duty_type [NUM_WHEELS-1:0] duty1_ff, duty1_in;
   lim_type                   lim1_ff;
   duty_type                  sp, tu, sf;

   always_comb begin
      sp = $signed({{(DUTY_W-IN_W){in_speed[IN_W-1]}}, in_speed});
      tu = $signed({{(DUTY_W-IN_W){in_turn[IN_W-1]}}, in_turn});
      sf = $signed({{(DUTY_W-IN_W){in_strafe[IN_W-1]}}, in_strafe});
      duty1_in[WHEEL_FR] = sp - tu - sf;
      duty1_in[WHEEL_FL] = sp + tu + sf;
      duty1_in[WHEEL_RR] = sp - tu + sf;
      duty1_in[WHEEL_RL] = sp + tu - sf;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         duty1_ff <= duty1_in;
         lim1_ff  <= in_lim;
      end
   end

   // stage 2: magnitudes and bound
   mag_type [NUM_WHEELS-1:0] mag;
   mag_type                  max01, max23, bound2_in, bound2_ff;
   duty_type [NUM_WHEELS-1:0] duty2_ff;
   lim_type                   lim2_ff;
   duty_type                  dsel;

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         dsel   = $signed(duty1_ff[w]);
         mag[w] = dsel[DUTY_W-1] ? MAG_W'(-dsel) : MAG_W'(dsel);
      end
      max01     = (mag[1] > mag[0]) ? mag[1] : mag[0];
      max23     = (mag[3] > mag[2]) ? mag[3] : mag[2];
      bound2_in = (max23 > max01) ? max23 : max01;
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         bound2_ff <= bound2_in;
         duty2_ff  <= duty1_ff;
         lim2_ff   <= lim1_ff;
      end
   end

   // stage 3: rescale decision, offset duties (never negative)
   logic [NUM_WHEELS-1:0][DUTY_W-1:0] ofs3_ff, ofs3_in;
   logic signed [DUTY_W:0]            sum;
   mag_type                           bound3_ff;
   duty_type [NUM_WHEELS-1:0]         duty3_ff;
   lim_type                           lim3_ff;
   logic                              resc3_ff;

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         sum = $signed({duty2_ff[w][DUTY_W-1], duty2_ff[w]})
             + $signed({2'b00, bound2_ff});
         ofs3_in[w] = sum[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         ofs3_ff   <= ofs3_in;
         resc3_ff  <= bound2_ff > {{(MAG_W-LIM_W){1'b0}}, lim2_ff};
         bound3_ff <= bound2_ff;
         duty3_ff  <= duty2_ff;
         lim3_ff   <= lim2_ff;
      end
   end

   // stage 4: numerators (duty + bound) * limit
   num_type [NUM_WHEELS-1:0] num4_in;
   div_in_type               out4_ff;

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         num4_in[w] = {{(NUM_W-DUTY_W){1'b0}}, ofs3_ff[w]}
                    * {{(NUM_W-LIM_W){1'b0}}, lim3_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         out4_ff.num     <= num4_in;
         out4_ff.bound   <= bound3_ff;
         out4_ff.duty    <= duty3_ff;
         out4_ff.lim     <= lim3_ff;
         out4_ff.rescale <= resc3_ff;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_data  = out4_ff;

endmodule

@@ rtl/mmp_div.sv @@
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// Quotient = num / bound; depends on mmp_pkg.
module mmp_div import mmp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  div_in_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output pwm_in_type out_data
);

   div_st_type src [QUO_W+1];
   div_st_type st_ff [QUO_W];
   logic       vld_ff [QUO_W];
   wire  [QUO_W:0] vsrc;
   wire  [QUO_W:0] rdy;

   assign src[0].rem     = in_data.num;
   assign src[0].quo     = '0;
   assign src[0].bound   = in_data.bound;
   assign src[0].duty    = in_data.duty;
   assign src[0].lim     = in_data.lim;
   assign src[0].rescale = in_data.rescale;
   assign vsrc[0]        = in_valid;
   assign rdy[QUO_W]     = out_ready;
   assign in_ready       = rdy[0];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      localparam int BIT = QUO_W - 1 - j;
      num_type    trial;
      div_st_type nxt;

      assign trial = num_type'(src[j].bound) << BIT;

      always_comb begin
         nxt = src[j];
         for (int w = 0; w < NUM_WHEELS; w++) begin
            if (src[j].rem[w] >= trial) begin
               nxt.rem[w]      = src[j].rem[w] - trial;
               nxt.quo[w][BIT] = 1'b1;
            end
         end
      end

      assign rdy[j] = !vld_ff[j] || rdy[j+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            vld_ff[j] <= vsrc[j];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j]) begin
            st_ff[j] <= nxt;
         end
      end

      assign src[j+1]  = st_ff[j];
      assign vsrc[j+1] = vld_ff[j];
   end

   assign out_valid        = vsrc[QUO_W];
   assign out_data.quo     = src[QUO_W].quo;
   assign out_data.duty    = src[QUO_W].duty;
   assign out_data.lim     = src[QUO_W].lim;
   assign out_data.rescale = src[QUO_W].rescale;

   // a stalled final stage keeps its transaction
   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[QUO_W-1] && !out_ready |=> vld_ff[QUO_W-1] && $stable(st_ff[QUO_W-1]))
      else $error("divider output stage lost data under stall");

endmodule

@@ rtl/mmp_pwm.sv @@
// Back of the pipeline: final duty, direction, PWM compare value.
// |duty| * (2^PWM_BITS - 1) / 100 via reciprocal multiply; depends on mmp_pkg.
module mmp_pwm import mmp_pkg::*; #(
   parameter int PWM_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  pwm_in_type                           in_data,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [NUM_WHEELS-1:0][DIR_W-1:0]     out_dir,
   output logic [NUM_WHEELS-1:0][PWM_BITS-1:0]  out_pwm
);

   localparam int PROD_W = PCT_W + PWM_BITS;
   localparam int K      = PROD_W + 7;
   localparam int RW     = K - 6;
   localparam int EST_W  = PROD_W + RW;
   localparam int Q_W    = EST_W - K;
   localparam logic [63:0] RECIP_L =
      ((64'd1 << K) + 64'(PCT_FULL - 1)) / 64'(PCT_FULL);
   localparam logic [RW-1:0]       RECIP = RECIP_L[RW-1:0];
   localparam logic [PWM_BITS-1:0] TOP   = '1;

   logic [3:0] vld_ff;
   logic [3:0] vld_in;
   logic [3:0] rdy;

   assign rdy[3]   = !vld_ff[3] || out_ready;
   assign rdy[2]   = !vld_ff[2] || rdy[3];
   assign rdy[1]   = !vld_ff[1] || rdy[2];
   assign rdy[0]   = !vld_ff[0] || rdy[1];
   assign in_ready = rdy[0];
   assign vld_in   = {vld_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < 4; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // stage 1: final duty, sign and magnitude
   logic [NUM_WHEELS-1:0][PCT_W-1:0] mag1_ff, mag1_in;
   logic [NUM_WHEELS-1:0][DIR_W-1:0] dir1_ff, dir1_in;
   lim_type                          lim1_ff;
   duty_type                         fin;

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         if (in_data.rescale) begin
            fin = $signed({{(DUTY_W-QUO_W){1'b0}}, in_data.quo[w]})
                - $signed({{(DUTY_W-LIM_W){1'b0}}, in_data.lim});
         end else begin
            fin = $signed(in_data.duty[w]);
         end
         mag1_in[w] = fin[DUTY_W-1] ? PCT_W'(-fin) : PCT_W'(fin);
         if (fin == '0) begin
            dir1_in[w] = DIR_STOP;
         end else if (fin[DUTY_W-1]) begin
            dir1_in[w] = DIR_BACK;
         end else begin
            dir1_in[w] = DIR_FWD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         mag1_ff <= mag1_in;
         dir1_ff <= dir1_in;
         lim1_ff <= in_data.lim;
      end
   end

   // stage 2: magnitude * full scale
   logic [NUM_WHEELS-1:0][PROD_W-1:0] prod2_ff;
   logic [NUM_WHEELS-1:0][DIR_W-1:0]  dir2_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         for (int w = 0; w < NUM_WHEELS; w++) begin
            prod2_ff[w] <= PROD_W'(mag1_ff[w]) * PROD_W'(TOP);
         end
         dir2_ff <= dir1_ff;
      end
   end

   // stage 3: times ceil(2^K / 100), exact floor for every product
   logic [NUM_WHEELS-1:0][EST_W-1:0] est3_ff;
   logic [NUM_WHEELS-1:0][DIR_W-1:0] dir3_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         for (int w = 0; w < NUM_WHEELS; w++) begin
            est3_ff[w] <= EST_W'(prod2_ff[w]) * EST_W'(RECIP);
         end
         dir3_ff <= dir2_ff;
      end
   end

   // stage 4: shift out quotient, saturate at full scale
   logic [NUM_WHEELS-1:0][PWM_BITS-1:0] pwm4_ff, pwm4_in;
   logic [NUM_WHEELS-1:0][DIR_W-1:0]    dir4_ff;
   logic [Q_W-1:0]                      qv;

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         qv = est3_ff[w][EST_W-1:K];
         pwm4_in[w] = (qv > {1'b0, TOP}) ? TOP : qv[PWM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         pwm4_ff <= pwm4_in;
         dir4_ff <= dir3_ff;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_dir   = dir4_ff;
   assign out_pwm   = pwm4_ff;

   a_mag_in_limit: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> (mag1_ff[WHEEL_FR] <= lim1_ff) && (mag1_ff[WHEEL_FL] <= lim1_ff)
                 && (mag1_ff[WHEEL_RR] <= lim1_ff) && (mag1_ff[WHEEL_RL] <= lim1_ff))
      else $error("final duty magnitude above scale limit");

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |->
         ((dir4_ff[WHEEL_FR] == DIR_STOP) == (pwm4_ff[WHEEL_FR] == '0))
      && ((dir4_ff[WHEEL_FL] == DIR_STOP) == (pwm4_ff[WHEEL_FL] == '0))
      && ((dir4_ff[WHEEL_RR] == DIR_STOP) == (pwm4_ff[WHEEL_RR] == '0))
      && ((dir4_ff[WHEEL_RL] == DIR_STOP) == (pwm4_ff[WHEEL_RL] == '0)))
      else $error("stop direction and zero compare value disagree");

endmodule

@@ rtl/mecanum_mix_to_pwm.sv @@
// Top level of the mecanum wheel mixer with PWM outputs.
// Depends on mmp_pkg, mmp_if, mmp_mix, mmp_div and mmp_pwm.
//
// Takes one drive command (speed, turn, strafe) per transaction and returns
// per wheel a direction code and a PWM compare value. The block is fully
// pipelined: it accepts one transaction every clock cycle while the output
// is not stalled, and each result passes through 16 register stages (4 mixing
// stages, 8 divider stages at one quotient bit each, 4 PWM conversion
// stages). Every stage has its own valid bit, so a stalled output backs up
// only the filled stages and bubbles are squeezed out. scale_limit resets to
// 90 and is written through csr_wr_en / csr_wr_data; the user must write it
// only while no transaction is in flight, as the block does not enforce it.
module mecanum_mix_to_pwm import mmp_pkg::*; #(
   parameter int PWM_BITS = 10
) (
   input  logic             clock,
   input  logic             reset,
   mmp_req_if.sink          req_bus,
   mmp_rsp_if.source        rsp_bus,
   input  logic             csr_wr_en,
   input  logic [LIM_W-1:0] csr_wr_data
);

   lim_type lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= LIM_RESET;
      end else if (csr_wr_en) begin
         lim_ff <= csr_wr_data;
      end
   end

   logic       mix_valid, mix_ready;
   div_in_type mix_data;
   logic       div_valid, div_ready;
   pwm_in_type div_data;

   logic [NUM_WHEELS-1:0][DIR_W-1:0]    wheel_dir;
   logic [NUM_WHEELS-1:0][PWM_BITS-1:0] wheel_pwm;

   mmp_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_speed  (req_bus.speed),
      .in_turn   (req_bus.turn),
      .in_strafe (req_bus.strafe),
      .in_lim    (lim_ff),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_data  (mix_data)
   );

   mmp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (mix_ready),
      .in_data   (mix_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   mmp_pwm #(.PWM_BITS(PWM_BITS)) u_pwm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_dir   (wheel_dir),
      .out_pwm   (wheel_pwm)
   );

   assign rsp_bus.dir_front_right = wheel_dir[WHEEL_FR];
   assign rsp_bus.pwm_front_right = wheel_pwm[WHEEL_FR];
   assign rsp_bus.dir_front_left  = wheel_dir[WHEEL_FL];
   assign rsp_bus.pwm_front_left  = wheel_pwm[WHEEL_FL];
   assign rsp_bus.dir_rear_right  = wheel_dir[WHEEL_RR];
   assign rsp_bus.pwm_rear_right  = wheel_pwm[WHEEL_RR];
   assign rsp_bus.dir_rear_left   = wheel_dir[WHEEL_RL];
   assign rsp_bus.pwm_rear_left   = wheel_pwm[WHEEL_RL];

endmodule
